// ===== sv/tptv_pkg.sv =====
// ----------------------------------------------------------------------------
// tptv_pkg
// Types, codes and constants shared by the two-phase termination voter.
// ----------------------------------------------------------------------------
package tptv_pkg;

	localparam int MAX_NODES     = 64;
	localparam int PENDING_WIDTH = 24;
	localparam int COUNT_WIDTH   = 24;
	localparam int NODES_WIDTH   = 7;
	localparam int ADDR_WIDTH    = 3;
	localparam int DATA_WIDTH    = 32;

	typedef enum logic [2:0] {
		MODE_ADD      = 3'd0,
		MODE_SUB      = 3'd1,
		MODE_PROPOSE  = 3'd2,
		MODE_VOTE_CMT = 3'd3,
		MODE_VOTE_ABT = 3'd4,
		MODE_COMMIT   = 3'd5,
		MODE_ABORT    = 3'd6,
		MODE_TICK     = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		SEND_NONE      = 3'd0,
		SEND_BC_PROP   = 3'd1,
		SEND_BC_COMMIT = 3'd2,
		SEND_BC_ABORT  = 3'd3,
		SEND_VOTE_CMT  = 3'd4,
		SEND_VOTE_ABT  = 3'd5
	} send_kind_t;

	typedef enum logic [2:0] {
		ST_PREP_COORD  = 3'd0,
		ST_PROPOSE     = 3'd1,
		ST_PREP_COHORT = 3'd2,
		ST_VOTE        = 3'd3,
		ST_TERMINATE   = 3'd4
	} fsm_state_t;

	typedef enum logic [ADDR_WIDTH-3:0] {
		REG_IS_COORD  = 1'd0,
		REG_NUM_NODES = 1'd1
	} reg_index_t;

	typedef struct packed {
		logic [2:0]             mode;
		logic [COUNT_WIDTH-1:0] count;
		logic                   local_done;
	} tptv_item_t;

	typedef struct packed {
		logic                   is_coordinator;
		logic [NODES_WIDTH-1:0] num_nodes;
		logic                   role_wr;
		logic                   role_coord;
	} tptv_cfg_t;

	typedef struct packed {
		send_kind_t             send_kind;
		logic                   all_done;
		logic                   comm_allowed;
		logic                   pending_underflow;
		logic [COUNT_WIDTH-1:0] pending_count;
	} tptv_result_t;

endpackage

// ===== sv/tptv_in_if.sv =====
// ----------------------------------------------------------------------------
// tptv_in_if
// Input channel of the voter: one event or tick word per handshake.
// ----------------------------------------------------------------------------
interface tptv_in_if
	import tptv_pkg::*;
	();
	logic                   valid;
	logic                   ready;
	logic [2:0]             mode;
	logic [COUNT_WIDTH-1:0] count;
	logic                   local_done;

	modport source (output valid, output mode, output count, output local_done, input ready);
	modport sink (input valid, input mode, input count, input local_done, output ready);
endinterface

// ===== sv/tptv_out_if.sv =====
// ----------------------------------------------------------------------------
// tptv_out_if
// Result channel of the voter: one result word per input word.
// ----------------------------------------------------------------------------
interface tptv_out_if
	import tptv_pkg::*;
	();
	logic                   valid;
	logic                   ready;
	logic [2:0]             send_kind;
	logic                   all_done;
	logic                   comm_allowed;
	logic                   pending_underflow;
	logic [COUNT_WIDTH-1:0] pending_count;

	modport source (output valid, output send_kind, output all_done, output comm_allowed,
		output pending_underflow, output pending_count, input ready);
	modport sink (input valid, input send_kind, input all_done, input comm_allowed,
		input pending_underflow, input pending_count, output ready);
endinterface

// ===== sv/tptv_apb_regs.sv =====
// ----------------------------------------------------------------------------
// tptv_apb_regs
// APB configuration registers: role select and node count.
// ----------------------------------------------------------------------------
module tptv_apb_regs
	import tptv_pkg::*;
	(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [DATA_WIDTH-1:0] pwdata,
	output logic [DATA_WIDTH-1:0] prdata,
	output logic                  pready,
	output tptv_cfg_t             cfg
);

	logic                   is_coord_q;
	logic [NODES_WIDTH-1:0] num_nodes_q;
	logic                   wr_en;
	reg_index_t             idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_index_t'(paddr[ADDR_WIDTH-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_coord_q  <= 1'b0;
			num_nodes_q <= NODES_WIDTH'(1);
		end else if (wr_en) begin
			case (idx)
				REG_IS_COORD:  is_coord_q  <= pwdata[0];
				REG_NUM_NODES: num_nodes_q <= pwdata[NODES_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IS_COORD:  prdata = {{(DATA_WIDTH-1){1'b0}}, is_coord_q};
			REG_NUM_NODES: prdata = {{(DATA_WIDTH-NODES_WIDTH){1'b0}}, num_nodes_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg.is_coordinator = is_coord_q;
	assign cfg.num_nodes      = num_nodes_q;
	assign cfg.role_wr        = wr_en && (idx == REG_IS_COORD);
	assign cfg.role_coord     = pwdata[0];

endmodule

// ===== sv/tptv_core.sv =====
// ----------------------------------------------------------------------------
// tptv_core
// Voter state and the step that applies one word to it.
// ----------------------------------------------------------------------------
module tptv_core
	import tptv_pkg::*;
	(
	input  logic         clk,
	input  logic         arst_n,
	input  tptv_cfg_t    cfg,
	input  logic         step,
	input  tptv_item_t   item,
	output tptv_result_t res
);

	localparam int SUM_WIDTH = ((PENDING_WIDTH > COUNT_WIDTH) ? PENDING_WIDTH : COUNT_WIDTH) + 1;
	localparam logic [SUM_WIDTH-1:0] PEND_MAX = SUM_WIDTH'((64'd1 << PENDING_WIDTH) - 64'd1);
	localparam logic [NODES_WIDTH-1:0] VOTE_CAP = {NODES_WIDTH{1'b1}};

	fsm_state_t               state_q, state_d;
	logic [PENDING_WIDTH-1:0] pend_q, pend_d;
	logic [NODES_WIDTH-1:0]   votes_q, votes_d;
	logic [NODES_WIDTH-1:0]   cvotes_q, cvotes_d;
	logic                     all_in_q, all_in_d;
	logic                     dec_in_q, dec_in_d;
	logic                     dec_cmt_q, dec_cmt_d;
	logic                     prop_in_q, prop_in_d;

	fsm_state_t             prep_state;
	logic [NODES_WIDTH-1:0] n_clamped;
	logic [NODES_WIDTH:0]   needed;
	logic [SUM_WIDTH-1:0]   pend_ext, cnt_ext, sum;
	logic                   has_work;
	send_kind_t             send;
	logic                   done, underflow;

	assign prep_state = cfg.is_coordinator ? ST_PREP_COORD : ST_PREP_COHORT;
	assign n_clamped  = (32'(cfg.num_nodes) > MAX_NODES) ? NODES_WIDTH'(MAX_NODES) : cfg.num_nodes;
	assign needed     = {1'b0, n_clamped} - (NODES_WIDTH+1)'(1);
	assign pend_ext   = SUM_WIDTH'(pend_q);
	assign cnt_ext    = SUM_WIDTH'(item.count);
	assign sum        = pend_ext + cnt_ext;
	assign has_work   = !(item.local_done && (pend_q == '0));

	always_comb begin
		state_d   = state_q;
		pend_d    = pend_q;
		votes_d   = votes_q;
		cvotes_d  = cvotes_q;
		all_in_d  = all_in_q;
		dec_in_d  = dec_in_q;
		dec_cmt_d = dec_cmt_q;
		prop_in_d = prop_in_q;
		send      = SEND_NONE;
		done      = 1'b0;
		underflow = 1'b0;
		case (mode_t'(item.mode))
			MODE_ADD: begin
				pend_d = (sum > PEND_MAX) ? PEND_MAX[PENDING_WIDTH-1:0] : sum[PENDING_WIDTH-1:0];
			end
			MODE_SUB: begin
				if (cnt_ext > pend_ext) begin
					pend_d    = '0;
					underflow = 1'b1;
				end else begin
					pend_d = pend_q - PENDING_WIDTH'(cnt_ext);
				end
			end
			MODE_PROPOSE: prop_in_d = 1'b1;
			MODE_VOTE_CMT, MODE_VOTE_ABT: begin
				if (item.mode == MODE_VOTE_CMT && cvotes_q != VOTE_CAP)
					cvotes_d = cvotes_q + NODES_WIDTH'(1);
				if (votes_q != VOTE_CAP)
					votes_d = votes_q + NODES_WIDTH'(1);
				if ({1'b0, votes_d} == needed)
					all_in_d = 1'b1;
			end
			MODE_COMMIT: begin
				dec_in_d  = 1'b1;
				dec_cmt_d = 1'b1;
			end
			MODE_ABORT: dec_in_d = 1'b1;
			default: begin
				case (state_q)
					ST_PREP_COORD: begin
						if (!has_work) begin
							send    = SEND_BC_PROP;
							state_d = ST_PROPOSE;
						end
					end
					ST_PROPOSE: begin
						if (all_in_q) begin
							if ({1'b0, cvotes_q} == needed) begin
								send    = SEND_BC_COMMIT;
								state_d = ST_TERMINATE;
								done    = 1'b1;
							end else begin
								send    = SEND_BC_ABORT;
								state_d = ST_PREP_COORD;
							end
							votes_d  = '0;
							cvotes_d = '0;
							all_in_d = 1'b0;
						end
					end
					ST_PREP_COHORT: begin
						if (prop_in_q) begin
							state_d   = ST_VOTE;
							prop_in_d = 1'b0;
							send      = has_work ? SEND_VOTE_ABT : SEND_VOTE_CMT;
						end
					end
					ST_VOTE: begin
						if (dec_in_q) begin
							if (dec_cmt_q) begin
								state_d = ST_TERMINATE;
								done    = 1'b1;
							end else begin
								state_d  = ST_PREP_COHORT;
								dec_in_d = 1'b0;
							end
						end
					end
					ST_TERMINATE: begin
						state_d   = prep_state;
						pend_d    = '0;
						votes_d   = '0;
						cvotes_d  = '0;
						all_in_d  = 1'b0;
						dec_in_d  = 1'b0;
						dec_cmt_d = 1'b0;
						prop_in_d = 1'b0;
					end
					default: ;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_PREP_COHORT;
			pend_q    <= '0;
			votes_q   <= '0;
			cvotes_q  <= '0;
			all_in_q  <= 1'b0;
			dec_in_q  <= 1'b0;
			dec_cmt_q <= 1'b0;
			prop_in_q <= 1'b0;
		end else if (cfg.role_wr) begin
			state_q <= cfg.role_coord ? ST_PREP_COORD : ST_PREP_COHORT;
		end else if (step) begin
			state_q   <= state_d;
			pend_q    <= pend_d;
			votes_q   <= votes_d;
			cvotes_q  <= cvotes_d;
			all_in_q  <= all_in_d;
			dec_in_q  <= dec_in_d;
			dec_cmt_q <= dec_cmt_d;
			prop_in_q <= prop_in_d;
		end
	end

	assign res.send_kind         = send;
	assign res.all_done          = done;
	assign res.comm_allowed      = (state_d == prep_state);
	assign res.pending_underflow = underflow;
	assign res.pending_count     = COUNT_WIDTH'(pend_d);

endmodule

// ===== sv/two_phase_termination_voter.sv =====
// ----------------------------------------------------------------------------
// two_phase_termination_voter
// Termination voter using two-phase commit, with an input register, a
// state update and a result register.
// ----------------------------------------------------------------------------
//  Channel   Kind           Word
//  items     valid/ready    mode, count, local_done
//  results   valid/ready    send_kind, all_done, comm_allowed,
//                           pending_underflow, pending_count
//  APB       psel/penable   is_coordinator at 0x0, num_nodes at 0x4
//
// One word is taken per cycle while the result channel does not stall; each word
// is held in the input register and its result is then offered from the result register.
// The state update happens as the word moves from the input register to the
// result register, so consecutive words see each other's effects.
// A stalled result holds in its register while one more word waits in the
// input register. Reset puts the node in the cohort prepare state.
// ----------------------------------------------------------------------------
module two_phase_termination_voter
	import tptv_pkg::*;
	(
	input  logic                  clk,
	input  logic                  arst_n,
	tptv_in_if.sink               items,
	tptv_out_if.source            results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [DATA_WIDTH-1:0] pwdata,
	output logic [DATA_WIDTH-1:0] prdata,
	output logic                  pready
);

	tptv_cfg_t    cfg;
	tptv_item_t   item_s1;
	logic         valid_s1;
	tptv_result_t res_comb;
	tptv_result_t res_s2;
	logic         valid_s2;
	logic         adv;

	tptv_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tptv_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (adv),
		.item   (item_s1),
		.res    (res_comb)
	);

	assign adv         = valid_s1 && (!valid_s2 || results.ready);
	assign items.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (items.ready)
				valid_s1 <= items.valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (results.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.mode       <= items.mode;
			item_s1.count      <= items.count;
			item_s1.local_done <= items.local_done;
		end
		if (adv)
			res_s2 <= res_comb;
	end

	assign results.valid             = valid_s2;
	assign results.send_kind         = res_s2.send_kind;
	assign results.all_done          = res_s2.all_done;
	assign results.comm_allowed      = res_s2.comm_allowed;
	assign results.pending_underflow = res_s2.pending_underflow;
	assign results.pending_count     = res_s2.pending_count;

endmodule
